// ===== design/vgo_pkg.sv =====
// shared types, constants and tables for the volume gradient operator
// no dependencies; imported by the top level, vgo_front, vgo_cordic, vgo_checker and the bench
`default_nettype none

package vgo_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int OUT_W           = 24;
   localparam int MODE_W          = 3;
   localparam int SPACE_W         = 16;
   localparam int IDX_W           = 2;
   localparam int LANES           = 6;
   localparam int DIV_SHIFT       = 13;

   localparam int SPACE_RESET     = 4096;
   localparam int OUT_MAX         = 8388607;
   localparam int OUT_MIN         = -8388608;

   // cordic
   localparam int CORDIC_STEPS    = 16;
   localparam int CORDIC_LAT      = CORDIC_STEPS + 2;
   localparam int FRAC_BITS       = 32;
   localparam int ANG_W           = 26;
   localparam int ANG_180         = 5898240;
   localparam int PHASE_ROUND     = 128;
   localparam int PHASE_SHIFT     = 8;
   localparam int PHASE_LIMIT     = 23040;
   localparam int PHASE_W         = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_NEIGH_NORM = 3'd0,
      MODE_AMPLITUDE  = 3'd1,
      MODE_PHASE      = 3'd2,
      MODE_DIVERGENCE = 3'd3,
      MODE_VORTICITY  = 3'd4
   } vgo_mode_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_MODE      = 2'd0,
      CSR_SPACING_X = 2'd1,
      CSR_SPACING_Y = 2'd2
   } vgo_csr_type;

   typedef struct packed {
      logic              valid;
      logic              border;
      logic [MODE_W-1:0] mode;
   } vgo_ctrl_type;

   // atan(2^-i) in 1/32768 degree
   function automatic logic signed [ANG_W-1:0] atan_step(input int i);
      logic signed [ANG_W-1:0] a;
      case (i)
         0:  a = ANG_W'(1474560);
         1:  a = ANG_W'(870484);
         2:  a = ANG_W'(459940);
         3:  a = ANG_W'(233473);
         4:  a = ANG_W'(117189);
         5:  a = ANG_W'(58652);
         6:  a = ANG_W'(29333);
         7:  a = ANG_W'(14667);
         8:  a = ANG_W'(7334);
         9:  a = ANG_W'(3667);
         10: a = ANG_W'(1833);
         11: a = ANG_W'(917);
         12: a = ANG_W'(458);
         13: a = ANG_W'(229);
         14: a = ANG_W'(115);
         15: a = ANG_W'(57);
         default: a = '0;
      endcase
      return a;
   endfunction

   // cycles from an accepted start to the result strobe
   function automatic int vgo_latency(input int sb);
      int isq_arr;
      int cor_arr;
      isq_arr = 3 + sb + 2;
      cor_arr = 1 + CORDIC_LAT;
      return ((isq_arr > cor_arr) ? isq_arr : cor_arr) + 2;
   endfunction

endpackage

`default_nettype wire

// ===== design/volume_gradient_operator.sv =====
// top level of the volume gradient operator: csr block, pipeline branches, output select
// depends on vgo_pkg, vgo_front, vgo_isqrt, vgo_cordic, vgo_delay
`default_nettype none

// Per-pixel finite-difference operator. One neighbourhood is taken on every
// clock at which start is high (busy is never raised), and exactly one result
// appears on rsp_pixel_out with rsp_valid high for a single cycle, after the
// delay that vgo_latency(SAMPLE_BITS) returns for the sample width. The
// latency is set by the longest branch: the square-root pipeline, which
// spends one stage per result bit (SAMPLE_BITS+2 stages after three front
// stages), or the 18-stage atan2 cordic; the shorter branches are delayed to
// meet it. Throughput is one transaction per clock and the receiver cannot
// stall. Registers (mode, inv_spacing_x, inv_spacing_y) are written through
// the csr port, which is always ready; write them only while no transaction
// is in flight. Mode codes 5 to 7 and the border flag give a zero result.

module volume_gradient_operator import vgo_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_center,
   input  logic signed [SAMPLE_BITS-1:0] req_west,
   input  logic signed [SAMPLE_BITS-1:0] req_east,
   input  logic signed [SAMPLE_BITS-1:0] req_south,
   input  logic signed [SAMPLE_BITS-1:0] req_north,
   input  logic signed [SAMPLE_BITS-1:0] req_below,
   input  logic signed [SAMPLE_BITS-1:0] req_above_or_diagonal,
   input  logic signed [SAMPLE_BITS-1:0] req_second_west,
   input  logic signed [SAMPLE_BITS-1:0] req_second_east,
   input  logic signed [SAMPLE_BITS-1:0] req_second_south,
   input  logic signed [SAMPLE_BITS-1:0] req_second_north,
   input  logic                          req_on_border,
   // result channel
   output logic                          rsp_valid,
   output logic signed [OUT_W-1:0]       rsp_pixel_out,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [IDX_W-1:0]              csr_index,
   input  logic [SPACE_W-1:0]            csr_data
);

   // datapath widths
   localparam int AW  = SAMPLE_BITS + 2;
   localparam int BW  = (AW > SPACE_W + 1) ? AW : SPACE_W + 1;
   localparam int PW  = AW + BW;
   localparam int SW  = PW + 3;
   localparam int QW  = 2 * SAMPLE_BITS + 4;
   localparam int RW  = QW / 2;
   localparam int DVW = SW - DIV_SHIFT;
   localparam int CW  = $bits(vgo_ctrl_type);

   // cycle at which each branch has its result in a register
   localparam int ISQ_ARR = 3 + RW;
   localparam int COR_ARR = 1 + CORDIC_LAT;
   localparam int ALIGN   = ((ISQ_ARR > COR_ARR) ? ISQ_ARR : COR_ARR) + 1;

   // configuration registers
   logic [MODE_W-1:0]  mode_ff;
   logic [SPACE_W-1:0] isx_ff;
   logic [SPACE_W-1:0] isy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NEIGH_NORM;
         isx_ff  <= SPACE_W'(SPACE_RESET);
         isy_ff  <= SPACE_W'(SPACE_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (vgo_csr_type'(csr_index))
            CSR_MODE:      mode_ff <= csr_data[MODE_W-1:0];
            CSR_SPACING_X: isx_ff  <= csr_data;
            CSR_SPACING_Y: isy_ff  <= csr_data;
            default: begin
               // index beyond the register list is dropped
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   // fully pipelined, a new transaction is taken every cycle
   assign busy = 1'b0;

   // front: differences, products and sum (three stages)
   vgo_ctrl_type         ctrl1;
   logic signed [AW-1:0] s1, s2;
   logic signed [SW-1:0] sum;

   vgo_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_border (req_on_border),
      .mode      (mode_ff),
      .isx       (isx_ff),
      .isy       (isy_ff),
      .center    (req_center),
      .west      (req_west),
      .east      (req_east),
      .south     (req_south),
      .north     (req_north),
      .below     (req_below),
      .diag      (req_above_or_diagonal),
      .sec_west  (req_second_west),
      .sec_east  (req_second_east),
      .sec_south (req_second_south),
      .sec_north (req_second_north),
      .ctrl1     (ctrl1),
      .s1        (s1),
      .s2        (s2),
      .sum       (sum)
   );

   // neighbour norm and amplitude: sum of squares is never negative
   logic [RW-1:0] root;

   vgo_isqrt #(.IN_W(QW)) u_isqrt (
      .clock (clock),
      .rad   (sum[QW-1:0]),
      .root  (root)
   );

   // phase: atan2 of the two roberts sums
   logic signed [PHASE_W-1:0] phase;

   vgo_cordic #(.IN_W(AW)) u_cordic (
      .clock (clock),
      .in_x  (s1),
      .in_y  (s2),
      .phase (phase)
   );

   // divergence and vorticity: floor of the scaled sum
   logic signed [DVW-1:0] dv;
   assign dv = DVW'(sum >>> DIV_SHIFT);

   // align all branches to the same cycle
   logic [CW-1:0]      ctrl_bits;
   vgo_ctrl_type       ctrl_al;
   logic [RW-1:0]      root_al;
   logic [PHASE_W-1:0] phase_al;
   logic [DVW-1:0]     dv_al;

   vgo_delay #(.W(CW), .DEPTH(ALIGN - 1)) u_dly_ctrl (
      .clock (clock), .reset (reset), .din (ctrl1), .dout (ctrl_bits)
   );
   assign ctrl_al = vgo_ctrl_type'(ctrl_bits);

   vgo_delay #(.W(RW), .DEPTH(ALIGN - ISQ_ARR)) u_dly_root (
      .clock (clock), .reset (reset), .din (root), .dout (root_al)
   );

   vgo_delay #(.W(PHASE_W), .DEPTH(ALIGN - COR_ARR)) u_dly_phase (
      .clock (clock), .reset (reset), .din (phase), .dout (phase_al)
   );

   vgo_delay #(.W(DVW), .DEPTH(ALIGN - 3)) u_dly_dv (
      .clock (clock), .reset (reset), .din (dv), .dout (dv_al)
   );

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 64'(OUT_MAX)) begin
         r = OUT_W'(OUT_MAX);
      end else if (v < 64'(OUT_MIN)) begin
         r = OUT_W'(OUT_MIN);
      end else begin
         r = OUT_W'(v);
      end
      return r;
   endfunction

   // output select and saturation
   logic signed [OUT_W-1:0] pix_in;
   logic signed [OUT_W-1:0] rsp_pixel_out_ff;
   logic                    rsp_valid_ff;

   always_comb begin
      pix_in = '0;
      if (!ctrl_al.border) begin
         unique case (ctrl_al.mode)
            MODE_NEIGH_NORM: pix_in = sat_out(64'(root_al));
            MODE_AMPLITUDE:  pix_in = sat_out(64'(root_al >> 1));
            MODE_PHASE:      pix_in = OUT_W'($signed(phase_al));
            MODE_DIVERGENCE,
            MODE_VORTICITY:  pix_in = sat_out(64'($signed(dv_al)));
            default:         pix_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_al.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_out_ff <= pix_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_out_ff;

endmodule

`default_nettype wire

// ===== design/vgo_delay.sv =====
// fixed-length register delay line used to align the pipeline branches
// depends on nothing
`default_nettype none

module vgo_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            tap_ff[k] <= '0;
         end
      end else begin
         tap_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/vgo_front.sv =====
// front end: differences, operand selection, products and their sum
// depends on vgo_pkg
`default_nettype none

module vgo_front import vgo_pkg::*; #(
   parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int AW = SAMPLE_BITS + 2,
   localparam int BW = (AW > SPACE_W + 1) ? AW : SPACE_W + 1,
   localparam int PW = AW + BW,
   localparam int SW = PW + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_border,
   input  logic [MODE_W-1:0]             mode,
   input  logic [SPACE_W-1:0]            isx,
   input  logic [SPACE_W-1:0]            isy,
   input  logic signed [SAMPLE_BITS-1:0] center,
   input  logic signed [SAMPLE_BITS-1:0] west,
   input  logic signed [SAMPLE_BITS-1:0] east,
   input  logic signed [SAMPLE_BITS-1:0] south,
   input  logic signed [SAMPLE_BITS-1:0] north,
   input  logic signed [SAMPLE_BITS-1:0] below,
   input  logic signed [SAMPLE_BITS-1:0] diag,
   input  logic signed [SAMPLE_BITS-1:0] sec_west,
   input  logic signed [SAMPLE_BITS-1:0] sec_east,
   input  logic signed [SAMPLE_BITS-1:0] sec_south,
   input  logic signed [SAMPLE_BITS-1:0] sec_north,
   output vgo_ctrl_type                  ctrl1,
   output logic signed [AW-1:0]          s1,
   output logic signed [AW-1:0]          s2,
   output logic signed [SW-1:0]          sum
);

   logic signed [AW-1:0] d [LANES];
   logic signed [AW-1:0] s1_n, s2_n;
   logic signed [BW-1:0] isx_s, isy_s;
   logic signed [AW-1:0] a_in [LANES];
   logic signed [BW-1:0] b_in [LANES];

   logic signed [AW-1:0] a_ff [LANES];
   logic signed [BW-1:0] b_ff [LANES];
   logic signed [AW-1:0] s1_ff, s2_ff;
   vgo_ctrl_type         ctrl_ff;
   logic signed [PW-1:0] p_ff [LANES];
   logic signed [SW-1:0] sum_in, sum_ff;

   always_comb begin
      d[0] = AW'(center) - AW'(west);
      d[1] = AW'(center) - AW'(east);
      d[2] = AW'(center) - AW'(south);
      d[3] = AW'(center) - AW'(north);
      d[4] = AW'(center) - AW'(below);
      d[5] = AW'(center) - AW'(diag);
      s1_n = d[1] + (AW'(north) - AW'(diag));
      s2_n = d[3] + (AW'(east) - AW'(diag));
      isx_s = BW'($signed({1'b0, isx}));
      isy_s = BW'($signed({1'b0, isy}));
   end

   // lane operands per mode; unused lanes multiply zero
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         a_in[k] = '0;
         b_in[k] = '0;
      end
      unique case (mode)
         MODE_NEIGH_NORM: begin
            for (int k = 0; k < LANES; k++) begin
               a_in[k] = d[k];
               b_in[k] = BW'(d[k]);
            end
         end
         MODE_AMPLITUDE: begin
            a_in[0] = s1_n;
            b_in[0] = BW'(s1_n);
            a_in[1] = s2_n;
            b_in[1] = BW'(s2_n);
         end
         MODE_DIVERGENCE: begin
            a_in[0] = AW'(east) - AW'(west);
            b_in[0] = isx_s;
            a_in[1] = AW'(sec_north) - AW'(sec_south);
            b_in[1] = isy_s;
         end
         MODE_VORTICITY: begin
            a_in[0] = AW'(sec_east) - AW'(sec_west);
            b_in[0] = isx_s;
            a_in[1] = AW'(south) - AW'(north);
            b_in[1] = isy_s;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < LANES; k++) begin
         sum_in = sum_in + SW'(p_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff.valid  <= in_valid;
         ctrl_ff.border <= in_border;
         ctrl_ff.mode   <= mode;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         a_ff[k] <= a_in[k];
         b_ff[k] <= b_in[k];
         p_ff[k] <= a_ff[k] * b_ff[k];
      end
      s1_ff  <= s1_n;
      s2_ff  <= s2_n;
      sum_ff <= sum_in;
   end

   assign ctrl1 = ctrl_ff;
   assign s1    = s1_ff;
   assign s2    = s2_ff;
   assign sum   = sum_ff;

endmodule

`default_nettype wire

// ===== design/vgo_isqrt.sv =====
// pipelined floor square root, one result bit per stage
// depends on nothing
`default_nettype none

module vgo_isqrt #(
   parameter  int IN_W = 36,
   localparam int RW   = IN_W / 2,
   localparam int REMW = RW + 3
) (
   input  logic            clock,
   input  logic [IN_W-1:0] rad,
   output logic [RW-1:0]   root
);

   logic [IN_W-1:0] rad_ff  [RW];
   logic [REMW-1:0] rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [IN_W-1:0] prad;
      logic [REMW-1:0] prem, rem_cat, trial;
      logic [RW-1:0]   proot;

      if (k == 0) begin : g_first
         assign prad  = rad;
         assign prem  = '0;
         assign proot = '0;
      end else begin : g_next
         assign prad  = rad_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
      end

      assign rem_cat = {prem[REMW-3:0], prad[IN_W-1:IN_W-2]};
      assign trial   = REMW'({proot, 2'b01});

      always_ff @(posedge clock) begin
         rad_ff[k] <= {prad[IN_W-3:0], 2'b00};
         if (rem_cat >= trial) begin
            rem_ff[k]  <= rem_cat - trial;
            root_ff[k] <= {proot[RW-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= rem_cat;
            root_ff[k] <= {proot[RW-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

`default_nettype wire

// ===== design/vgo_cordic.sv =====
// pipelined vectoring cordic giving atan2 in 1/128 degree
// depends on vgo_pkg
`default_nettype none

module vgo_cordic import vgo_pkg::*; #(
   parameter  int IN_W = SAMPLE_BITS_DEF + 2,
   localparam int W    = IN_W + 3 + FRAC_BITS,
   localparam int ZW   = ANG_W + 1
) (
   input  logic                      clock,
   input  logic signed [IN_W-1:0]    in_x,
   input  logic signed [IN_W-1:0]    in_y,
   output logic signed [PHASE_W-1:0] phase
);

   logic signed [W-1:0]     x_ff [CORDIC_STEPS+1];
   logic signed [W-1:0]     y_ff [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] z_ff [CORDIC_STEPS+1];
   logic                    zero_ff [CORDIC_STEPS+1];

   logic signed [W-1:0]     x_sc, y_sc;
   logic signed [ZW-1:0]    z_rnd, r_sh;
   logic signed [PHASE_W-1:0] phase_in, phase_ff;

   // pre-rotation into the right half plane
   always_comb begin
      x_sc = W'(in_x) <<< FRAC_BITS;
      y_sc = W'(in_y) <<< FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      if (x_sc[W-1]) begin
         x_ff[0] <= -x_sc;
         y_ff[0] <= -y_sc;
         z_ff[0] <= y_sc[W-1] ? -ANG_W'(ANG_180) : ANG_W'(ANG_180);
      end else begin
         x_ff[0] <= x_sc;
         y_ff[0] <= y_sc;
         z_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [W-1:0] xs, ys;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;

      always_ff @(posedge clock) begin
         zero_ff[k+1] <= zero_ff[k];
         if (!y_ff[k][W-1]) begin
            x_ff[k+1] <= x_ff[k] + ys;
            y_ff[k+1] <= y_ff[k] - xs;
            z_ff[k+1] <= z_ff[k] + atan_step(k);
         end else begin
            x_ff[k+1] <= x_ff[k] - ys;
            y_ff[k+1] <= y_ff[k] + xs;
            z_ff[k+1] <= z_ff[k] - atan_step(k);
         end
      end
   end

   // round to 1/128 degree, halves up, then clamp; a zero vector gives zero
   always_comb begin
      z_rnd = ZW'(z_ff[CORDIC_STEPS]) + ZW'(PHASE_ROUND);
      r_sh  = z_rnd >>> PHASE_SHIFT;
      if (zero_ff[CORDIC_STEPS]) begin
         phase_in = '0;
      end else if (r_sh > ZW'(PHASE_LIMIT)) begin
         phase_in = PHASE_W'(PHASE_LIMIT);
      end else if (r_sh < -ZW'(PHASE_LIMIT)) begin
         phase_in = -PHASE_W'(PHASE_LIMIT);
      end else begin
         phase_in = PHASE_W'(r_sh);
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

// ===== design/vgo_checker.sv =====
// port-level checks for volume_gradient_operator, bound to the top level
// depends on vgo_pkg
`default_nettype none

module vgo_checker import vgo_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    req_on_border,
   input logic                    rsp_valid,
   input logic signed [OUT_W-1:0] rsp_pixel_out
);

   localparam int LAT = vgo_latency(SAMPLE_BITS);

   // every accepted transaction gives its strobe a fixed time later
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted transaction produced no result");

   // no result without a matching transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without transaction");

   // border pixels give zero
   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_on_border) |-> ##LAT (rsp_pixel_out == '0))
      else $error("border pixel gave non-zero result");

endmodule

bind volume_gradient_operator vgo_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_vgo_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_on_border (req_on_border),
   .rsp_valid     (rsp_valid),
   .rsp_pixel_out (rsp_pixel_out)
);

`default_nettype wire

// ===== bench/tb_volume_gradient_operator.sv =====
// self-checking testbench for the volume gradient operator
// depends on vgo_pkg and volume_gradient_operator; predicts every pixel in-bench
`default_nettype none

module tb_volume_gradient_operator;
   import vgo_pkg::*;

   localparam int SB        = 16;
   localparam int LATENCY   = vgo_latency(SB);
   localparam int STALL_MAX = 2000;

   // register index outside the list, writes to it are dropped
   localparam logic [IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one neighbourhood as presented on the request ports
   typedef struct packed {
      logic signed [SB-1:0] center;
      logic signed [SB-1:0] west;
      logic signed [SB-1:0] east;
      logic signed [SB-1:0] south;
      logic signed [SB-1:0] north;
      logic signed [SB-1:0] below;
      logic signed [SB-1:0] diag;
      logic signed [SB-1:0] sec_west;
      logic signed [SB-1:0] sec_east;
      logic signed [SB-1:0] sec_south;
      logic signed [SB-1:0] sec_north;
      logic                 border;
   } hood_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   hood_type               hood;
   logic                   rsp_valid;
   logic signed [OUT_W-1:0] rsp_pixel_out;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [IDX_W-1:0]       csr_index;
   logic [SPACE_W-1:0]     csr_data;

   // mirror of the block's registers, updated on each accepted write
   logic [MODE_W-1:0]      mir_mode;
   logic [SPACE_W-1:0]     mir_isx;
   logic [SPACE_W-1:0]     mir_isy;

   logic signed [OUT_W-1:0] pixel_queue[$];
   int                     mismatches;
   int                     stall_count;
   bit                     gaps_on;

   volume_gradient_operator #(.SAMPLE_BITS(SB)) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_center            (hood.center),
      .req_west              (hood.west),
      .req_east              (hood.east),
      .req_south             (hood.south),
      .req_north             (hood.north),
      .req_below             (hood.below),
      .req_above_or_diagonal (hood.diag),
      .req_second_west       (hood.sec_west),
      .req_second_east       (hood.sec_east),
      .req_second_south      (hood.sec_south),
      .req_second_north      (hood.sec_north),
      .req_on_border         (hood.border),
      .rsp_valid             (rsp_valid),
      .rsp_pixel_out         (rsp_pixel_out),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor square root, bit by bit
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // vectoring cordic, angle in 1/32768 degree, rounded to 1/128 degree
   function automatic longint phase_angle(input longint sx, input longint sy);
      longint x, y, z, xs, ys, r;
      z = 0;
      if (sx == 0 && sy == 0) return 0;
      x = sx * 64'sd4294967296;
      y = sy * 64'sd4294967296;
      if (x < 0) begin
         z = (y >= 0) ? ANG_180 : -ANG_180;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(atan_step(i));
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(atan_step(i));
         end
      end
      r = (z + PHASE_ROUND) >>> PHASE_SHIFT;
      if (r > PHASE_LIMIT) r = PHASE_LIMIT;
      if (r < -PHASE_LIMIT) r = -PHASE_LIMIT;
      return r;
   endfunction

   // expected output pixel for one neighbourhood under the mirrored registers
   function automatic logic signed [OUT_W-1:0] gradient_pixel(input hood_type h);
      longint c, w, e, s, n, b, d, sw, se, ss, sn, isx, isy, s1, s2, r;
      longint unsigned q;
      c = h.center; w = h.west; e = h.east; s = h.south; n = h.north;
      b = h.below; d = h.diag;
      sw = h.sec_west; se = h.sec_east; ss = h.sec_south; sn = h.sec_north;
      isx = longint'(mir_isx);
      isy = longint'(mir_isy);
      s1 = (c - e) + (n - d);
      s2 = (c - n) + (e - d);
      r = 0;
      if (!h.border) begin
         case (mir_mode)
            MODE_NEIGH_NORM: begin
               q = (c-w)*(c-w) + (c-e)*(c-e) + (c-s)*(c-s)
                 + (c-n)*(c-n) + (c-b)*(c-b) + (c-d)*(c-d);
               r = longint'(floor_sqrt(q));
            end
            MODE_AMPLITUDE:  r = longint'(floor_sqrt(s1*s1 + s2*s2) >> 1);
            MODE_PHASE:      r = phase_angle(s1, s2);
            MODE_DIVERGENCE: r = ((e - w) * isx + (sn - ss) * isy) >>> DIV_SHIFT;
            MODE_VORTICITY:  r = ((se - sw) * isx - (n - s) * isy) >>> DIV_SHIFT;
            default:         r = 0;
         endcase
      end
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return r[OUT_W-1:0];
   endfunction

   // acceptance, register mirror, result check and watchdog on one edge
   always @(posedge clock) begin
      if (reset) begin
         mir_mode    <= MODE_NEIGH_NORM;
         mir_isx     <= SPACE_W'(SPACE_RESET);
         mir_isy     <= SPACE_W'(SPACE_RESET);
         stall_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (pixel_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: pixel_out %0d", rsp_pixel_out);
            end else begin
               logic signed [OUT_W-1:0] want;
               want = pixel_queue.pop_front();
               if (rsp_pixel_out !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pixel_out mismatch: expected %0d, got %0d",
                              want, rsp_pixel_out);
               end
            end
         end
         if (start && !busy)
            pixel_queue.push_back(gradient_pixel(hood));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:      mir_mode <= csr_data[MODE_W-1:0];
               CSR_SPACING_X: mir_isx  <= csr_data;
               CSR_SPACING_Y: mir_isy  <= csr_data;
               default: ;   // unused index, write dropped
            endcase
         end
         // watchdog: cycles in which nothing at all is accepted
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_count <= 0;
         end else if (stall_count + 1 >= STALL_MAX) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   // one transaction on the request channel, with random gaps before it while gaps_on is set
   task automatic send_hood(input hood_type h);
      while (gaps_on && $urandom_range(0, 99) < 32) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      hood  <= h;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SPACE_W-1:0] val);
      start     <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // let every pending pixel come back, then the pipeline empty out
   task automatic drain_pipe();
      start <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic set_regs(input logic [SPACE_W-1:0] m, input logic [SPACE_W-1:0] x,
                           input logic [SPACE_W-1:0] y);
      drain_pipe();
      write_reg(CSR_MODE, m);
      write_reg(CSR_SPACING_X, x);
      write_reg(CSR_SPACING_Y, y);
   endtask

   // sample value: full range, extremes or small values near zero
   function automatic logic signed [SB-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1:       return SB'($urandom_range(0, 16)) - 16'sd8;
         default: return SB'($urandom);
      endcase
   endfunction

   function automatic hood_type random_hood();
      hood_type h;
      h.center    = pick_sample();
      h.west      = pick_sample();
      h.east      = pick_sample();
      h.south     = pick_sample();
      h.north     = pick_sample();
      h.below     = pick_sample();
      h.diag      = pick_sample();
      h.sec_west  = pick_sample();
      h.sec_east  = pick_sample();
      h.sec_south = pick_sample();
      h.sec_north = pick_sample();
      h.border    = ($urandom_range(0, 9) == 0);
      // flat neighbourhood now and then, so both 2x2 sums vanish
      if ($urandom_range(0, 19) == 0) begin
         h.east  = h.center;
         h.north = h.center;
         h.diag  = h.center;
      end
      return h;
   endfunction

   function automatic hood_type flat_hood(input logic signed [SB-1:0] v);
      hood_type h;
      h = {{11{v}}, 1'b0};
      return h;
   endfunction

   // register defaults after reset, neighbour norm with extremes and the border flag
   task automatic test_reset_defaults();
      hood_type h;
      h = flat_hood(16'sh8000);
      h.center = 16'sh7fff;
      send_hood(h);
      send_hood(flat_hood(16'sd0));
      h.border = 1'b1;
      send_hood(h);
      h = flat_hood(16'sh7fff);
      h.center = 16'sh8000;
      send_hood(h);
   endtask

   // every mode on hand-picked extremes, including the flat phase case
   task automatic test_each_mode();
      hood_type h;
      for (int m = 0; m < 8; m++) begin
         set_regs(SPACE_W'(m), 16'hffff, 16'hffff);
         h = flat_hood(16'sh8000);
         h.center = 16'sh7fff; h.east = 16'sh7fff; h.sec_east = 16'sh7fff;
         h.sec_north = 16'sh7fff;
         send_hood(h);
         send_hood(flat_hood(16'sd5));
         h.border = 1'b1;
         send_hood(h);
      end
   endtask

   // spacing extremes, zero spacing and a write to the unused index
   task automatic test_spacing_extremes();
      hood_type h;
      h = random_hood();
      h.border = 1'b0;
      set_regs(SPACE_W'(MODE_DIVERGENCE), 16'd1, 16'd0);
      write_reg(CSR_UNUSED, 16'h0004);
      send_hood(h);
      set_regs(SPACE_W'(MODE_VORTICITY), 16'd0, 16'd65535);
      send_hood(h);
   endtask

   // random neighbourhoods over a sequence of random register settings
   task automatic test_random_traffic();
      logic [SPACE_W-1:0] m, x, y;
      for (int phase = 0; phase < 12; phase++) begin
         m = ($urandom_range(0, 9) == 0) ? SPACE_W'($urandom_range(5, 7))
                                         : SPACE_W'(phase % 5);
         m[SPACE_W-1:MODE_W] = (SPACE_W-MODE_W)'($urandom);
         case ($urandom_range(0, 3))
            0:       begin x = 16'd1;     y = 16'd65535; end
            1:       begin x = 16'd65535; y = 16'd1;     end
            default: begin x = SPACE_W'($urandom); y = SPACE_W'($urandom); end
         endcase
         set_regs(m, x, y);
         gaps_on = (phase != 6);   // one phase runs back to back
         for (int k = 0; k < 118; k++)
            send_hood(random_hood());
         gaps_on = 1'b1;
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      hood        = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_MODE;
      csr_data    = '0;
      mismatches  = 0;
      gaps_on     = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_each_mode();
      test_spacing_extremes();
      test_random_traffic();
      drain_pipe();
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
